// ===== rtl/tplru_pkg.sv =====
// Shared widths, command codes and defaults of the tree PLRU victim selector.
`timescale 1ns / 1ps
`default_nettype none

package tplru_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W     = 2;
    localparam int SET_IDX_W = 6;
    localparam int WAY_W     = 4;
    localparam int MASK_W    = 16;
    localparam int LIMIT_W   = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd2;

    // Reset value of the preserve limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    // Default geometry
    localparam int DEF_WAYS = 16;
    localparam int DEF_SETS = 64;

endpackage : tplru_pkg

`default_nettype wire

// ===== rtl/tree_plru_preserve_victim_select_top.sv =====
// Tree PLRU victim selector with a preserve tree, one set RAM holding both trees per set.
// Touch or invalidate: busy through the RAM read state, then the update and write-back state.
// Victim request: RAM read, then up to WAYS walks, one per run state, then a registered strobe.
// One transaction at a time: start is taken only while idle, not during a search or update.
// Reset: a clearing pass zeroes the set RAM, one set a cycle, with busy held high.
// The receiver cannot stall: each victim_way is shown for exactly one cycle with its strobe.
`timescale 1ns / 1ps
`default_nettype none

module tree_plru_preserve_victim_select_top #(
    parameter int WAYS = tplru_pkg::DEF_WAYS,
    parameter int SETS = tplru_pkg::DEF_SETS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Command channel
    input  wire                              start,
    output logic                             busy,
    input  wire  [tplru_pkg::CMD_W-1:0]      i_cmd,
    input  wire  [tplru_pkg::SET_IDX_W-1:0]  i_set_index,
    input  wire  [tplru_pkg::WAY_W-1:0]      i_way,
    input  wire  [tplru_pkg::MASK_W-1:0]     i_preserve_mask,
    // Result strobe
    output logic                             o_victim_valid,
    output logic [tplru_pkg::WAY_W-1:0]      o_victim_way,
    // Configuration write channel (preserve limit)
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [tplru_pkg::LIMIT_W-1:0]    i_cfg_data
);

    import tplru_pkg::*;

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    localparam int TW     = WAYS - 1;                       // node bits per tree
    localparam int NW     = $clog2(2 * WAYS - 1);           // heap node index
    localparam int VW     = $clog2(WAYS);                   // way number
    localparam int LVL    = $clog2(WAYS);                   // deepest leaf level
    localparam int IW     = $clog2(WAYS);                   // walk counter
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;  // RAM address
    localparam int CNT_W  = $clog2(MASK_W + 1);             // preserved way count
    localparam int NSET_IN = 1 << SET_IDX_W;

    // Mask bits that name a real way
    localparam logic [MASK_W-1:0] WAY_MASK =
        (WAYS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << WAYS) - 1);

    // State codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    typedef struct packed {
        logic [VW-1:0] victim;   // way reached by the walk
        logic [TW-1:0] tree;     // tree with the walked path turned away
    } t_walk;

    // ------------------------------------------------------------------
    // Tree helpers
    // ------------------------------------------------------------------
    // Set every node above a leaf: toward points at the leaf, else away.
    function automatic logic [TW-1:0] f_path_update(
        input logic [TW-1:0] tree,
        input logic [NW-1:0] leaf,
        input logic          toward
    );
        logic [TW-1:0] res;
        logic [NW-1:0] node;
        logic          from_right;
        res  = tree;
        node = leaf;
        for (int l = 0; l < LVL; l++) begin
            if (node != '0) begin
                from_right = ~node[0];
                node       = (node - NW'(1)) >> 1;
                if (from_right == toward) begin
                    res = res | (TW'(1) << node);
                end else begin
                    res = res & ~(TW'(1) << node);
                end
            end
        end
        return res;
    endfunction

    // Follow the node bits down to a leaf. Every node passed points at the
    // leaf, so flipping it is the promotion of that leaf.
    function automatic t_walk f_walk(input logic [TW-1:0] tree);
        t_walk         res;
        logic [NW-1:0] node;
        logic          dir;
        res.tree = tree;
        node     = '0;
        for (int l = 0; l < LVL; l++) begin
            if (node < NW'(WAYS - 1)) begin
                dir      = |(res.tree & (TW'(1) << node));
                res.tree = res.tree ^ (TW'(1) << node);
                node     = (node << 1) + NW'(1) + NW'(dir);
            end
        end
        res.victim = VW'(node - NW'(WAYS - 1));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Set index fold: constant table of index modulo SETS
    // ------------------------------------------------------------------
    logic [SET_W-1:0] set_fold [NSET_IN];

    for (genvar k = 0; k < NSET_IN; k++) begin : g_fold
        assign set_fold[k] = SET_W'(k % SETS);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]          r_state,    n_state;
    logic [SET_W-1:0]    r_clr_addr, n_clr_addr;
    logic [IW-1:0]       r_iter,     n_iter;
    logic                r_valid,    n_valid;
    logic [WAY_W-1:0]    r_victim,   n_victim;
    logic [LIMIT_W-1:0]  r_limit;

    // Held transaction
    logic [CMD_W-1:0]    r_cmd;
    logic [SET_W-1:0]    r_set;
    logic [WAY_W-1:0]    r_way;
    logic [MASK_W-1:0]   r_mask;
    logic                r_want;

    // Working copies of both trees
    logic [TW-1:0]       r_lru, n_lru;
    logic [TW-1:0]       r_prs, n_prs;

    // Set RAM: {preserve tree, LRU tree} per set
    logic [2*TW-1:0]     r_mem [SETS];
    logic [2*TW-1:0]     r_rd;

    logic                accept;
    logic [MASK_W-1:0]   mask_eff;
    logic [CNT_W-1:0]    pres_cnt;
    logic                mem_we;
    logic [SET_W-1:0]    wr_addr;
    logic [2*TW-1:0]     wr_data;
    t_walk               walk;
    logic [TW-1:0]       work_tree;
    logic [MASK_W-1:0]   mask_sh;
    logic                hit;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign o_cfg_ready  = 1'b1;
    assign o_victim_valid = r_valid;
    assign o_victim_way   = r_victim;

    // Count preserved ways at accept; only ways below WAYS carry a flag
    assign mask_eff = i_preserve_mask & WAY_MASK;
    assign pres_cnt = CNT_W'($countones(mask_eff));

    // Walk the tree selected for this victim search
    assign work_tree = r_want ? r_prs : r_lru;
    assign walk      = f_walk(work_tree);
    assign mask_sh   = r_mask >> walk.victim;
    assign hit       = (mask_sh[0] == r_want);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_iter     = r_iter;
        n_valid    = 1'b0;
        n_victim   = r_victim;
        n_lru      = r_lru;
        n_prs      = r_prs;
        mem_we     = 1'b0;
        wr_addr    = r_set;
        wr_data    = {r_prs, r_lru};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end

            S_LOAD: begin
                // RAM data of the set arrives; take both trees
                n_lru   = r_rd[TW-1:0];
                n_prs   = r_rd[2*TW-1:TW];
                n_iter  = '0;
                n_state = S_RUN;
            end

            S_RUN: begin
                if (r_cmd == CMD_VICTIM) begin
                    if (hit || (r_iter == IW'(WAYS - 1))) begin
                        // Search ends: write back, strobe the way reached
                        if (!hit) begin
                            if (r_want) begin
                                wr_data = {walk.tree, r_lru};
                            end else begin
                                wr_data = {r_prs, walk.tree};
                            end
                        end
                        mem_we   = 1'b1;
                        n_valid  = 1'b1;
                        n_victim = WAY_W'(walk.victim);
                        n_state  = S_IDLE;
                    end else begin
                        // Promote the unsuitable way and walk again
                        if (r_want) begin
                            n_prs = walk.tree;
                        end else begin
                            n_lru = walk.tree;
                        end
                        n_iter = r_iter + IW'(1);
                    end
                end else begin
                    // Touch or invalidate; other codes leave the set alone
                    if (((r_cmd == CMD_TOUCH) || (r_cmd == CMD_INVAL))
                        && (7'(r_way) < 7'(WAYS))) begin
                        mem_we  = 1'b1;
                        wr_data = {r_prs,
                                   f_path_update(r_lru, NW'(WAYS - 1) + NW'(r_way),
                                                 r_cmd == CMD_INVAL)};
                    end
                    n_state = S_IDLE;
                end
            end

            S_CLEAR: begin
                // Zero one set per cycle after reset
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (r_clr_addr == SET_W'(SETS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + SET_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
            r_limit    <= LIMIT_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_iter   <= n_iter;
        r_victim <= n_victim;
        r_lru    <= n_lru;
        r_prs    <= n_prs;
        if (accept) begin
            // Capture the transaction and decide which tree to search
            r_cmd  <= i_cmd;
            r_set  <= set_fold[i_set_index];
            r_way  <= i_way;
            r_mask <= mask_eff;
            r_want <= (pres_cnt > CNT_W'(r_limit));
        end
    end

    // ------------------------------------------------------------------
    // Set RAM, registered read output
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_mem[set_fold[i_set_index]];
        end
    end

`ifndef SYNTHESIS
    // A result follows only the last cycle of a victim search
    a_valid_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == S_RUN) && (r_cmd == CMD_VICTIM))
        else $error("victim strobe without a finished victim search");

    // An accepted command goes to the RAM read cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("accepted command did not start a RAM read");

    // The RAM is written only while updating a set or clearing
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_RUN) || (r_state == S_CLEAR))
        else $error("set RAM written outside update or clear");

    // A search ends after at most WAYS walks
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_cmd == CMD_VICTIM) && (r_iter == IW'(WAYS - 1))
        |=> (r_state == S_IDLE) && r_valid)
        else $error("victim search ran past its walk limit");
`endif

endmodule : tree_plru_preserve_victim_select_top

`default_nettype wire

// ===== dv/tb_tree_plru_preserve_victim_select_top.sv =====
// Self-checking testbench for the tree PLRU victim selector with its preserve tree.
`timescale 1ns / 1ps

module tb_tree_plru_preserve_victim_select_top;
    import tplru_pkg::*;

    localparam int WAYS          = DEF_WAYS;
    localparam int SETS          = DEF_SETS;
    localparam int TREE_W        = WAYS - 1;
    // Longest victim search is WAYS walks plus the RAM read and write back
    localparam int SETTLE_CYCLES = WAYS + 8;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int PHASE_OPS     = 250;
    localparam int MAX_PRINTS    = 100;

    // Spare encoding of the command field: the block must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_W-1:0]     way;
        logic [MASK_W-1:0]    mask;
    } plru_op_t;

    // Block ports; every input starts at a known value
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_cmd           = CMD_TOUCH;
    logic [SET_IDX_W-1:0]  i_set_index     = '0;
    logic [WAY_W-1:0]      i_way           = '0;
    logic [MASK_W-1:0]     i_preserve_mask = '0;
    logic                  o_victim_valid;
    logic [WAY_W-1:0]      o_victim_way;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [LIMIT_W-1:0]    i_cfg_data      = '0;

    // Stimulus and scoreboard state
    plru_op_t              pending_ops[$];
    logic [WAY_W-1:0]      victim_due[$];
    int unsigned           ops_queued      = 0;
    int unsigned           ops_accepted    = 0;
    int unsigned           gap_left        = 0;
    bit                    no_idle         = 1'b0;
    int unsigned           fail_count      = 0;

    // Shadow of the block state: both trees of every set and the limit register
    logic [TREE_W-1:0]     lru_model  [SETS];
    logic [TREE_W-1:0]     keep_model [SETS];
    logic [LIMIT_W-1:0]    limit_model     = LIMIT_RESET;

    tree_plru_preserve_victim_select_top #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_set_index     (i_set_index),
        .i_way           (i_way),
        .i_preserve_mask (i_preserve_mask),
        .o_victim_valid  (o_victim_valid),
        .o_victim_way    (o_victim_way),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Point every node on the path of a way toward it, or away from it.
    // Node n has children 2n+1 and 2n+2; a node bit of 1 points right.
    function automatic logic [TREE_W-1:0] steer_path(logic [TREE_W-1:0] tree,
                                                     logic [WAY_W-1:0] w, bit toward);
        int node;
        bit from_right;
        node = TREE_W + int'(w);
        do begin
            from_right = (node % 2) == 0;
            node = (node - 1) / 2;
            tree[node] = (from_right == toward);
        end while (node != 0);
        return tree;
    endfunction

    // Follow the node bits from the root down to a leaf and return its way
    function automatic logic [WAY_W-1:0] follow_tree(logic [TREE_W-1:0] tree);
        int node;
        node = 0;
        while (node < TREE_W)
            node = tree[node] ? 2 * node + 2 : 2 * node + 1;
        return WAY_W'(node - TREE_W);
    endfunction

    // Advance the shadow state by one accepted transaction and queue the
    // victim it must produce, if any
    function automatic void apply_op(plru_op_t op);
        int                 set_sel;
        int                 kept;
        bit                 want_kept;
        logic [TREE_W-1:0]  tree;
        logic [WAY_W-1:0]   pick;
        set_sel = int'(op.set_index) % SETS;
        pick = '0;
        case (op.cmd)
            CMD_TOUCH, CMD_INVAL: begin
                lru_model[set_sel] = steer_path(lru_model[set_sel], op.way,
                                                op.cmd == CMD_INVAL);
            end
            CMD_VICTIM: begin
                kept = $countones(op.mask[WAYS-1:0]);
                want_kept = kept > int'(limit_model);
                tree = want_kept ? keep_model[set_sel] : lru_model[set_sel];
                // Walk, and push the unsuitable way away, until a suitable one turns up
                for (int i = 0; i < WAYS; i++) begin
                    pick = follow_tree(tree);
                    if (op.mask[pick] == want_kept)
                        break;
                    tree = steer_path(tree, pick, 1'b0);
                end
                if (want_kept)
                    keep_model[set_sel] = tree;
                else
                    lru_model[set_sel] = tree;
                victim_due.push_back(pick);
            end
            default: begin
                // spare command: nothing changes, nothing comes back
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s (got %0d, expected %0d)", $time, what, got, want);
    endtask

    // Most transactions follow at once, some after a few idle cycles, a few after many
    function automatic int unsigned pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Put the oldest pending transaction on the command ports
    task launch_next();
        plru_op_t op;
        op = pending_ops.pop_front();
        i_cmd           <= op.cmd;
        i_set_index     <= op.set_index;
        i_way           <= op.way;
        i_preserve_mask <= op.mask;
        start           <= 1'b1;
    endtask

    // Driver: a transaction is taken at an edge with start high and busy low.
    // Predict it from the port values it was taken with, then either hold start
    // for the next one or drop it for a gap.
    always @(posedge i_clk) begin : driver
        int unsigned g;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            apply_op('{cmd: i_cmd, set_index: i_set_index, way: i_way,
                       mask: i_preserve_mask});
            ops_accepted++;
            g = pick_gap();
            if (g == 0 && pending_ops.size() > 0) begin
                launch_next();
            end else begin
                start    <= 1'b0;
                gap_left <= (g == 0) ? 0 : g - 1;
            end
        end else if (!start) begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_ops.size() > 0)
                launch_next();
        end
    end

    // Monitor: a strobe cannot be held off, so check it at the edge that ends its cycle
    always @(posedge i_clk) begin : monitor
        logic [WAY_W-1:0] want;
        if (i_rst_n && o_victim_valid === 1'b1) begin
            if (victim_due.size() == 0) begin
                flag_mismatch("victim strobe with no request outstanding",
                              int'(o_victim_way), -1);
            end else begin
                want = victim_due.pop_front();
                if (o_victim_way !== want)
                    flag_mismatch("victim_way", int'(o_victim_way), int'(want));
            end
        end
    end

    task automatic queue_op(input logic [CMD_W-1:0] cmd, input int set_index,
                            input int way, input logic [MASK_W-1:0] mask);
        pending_ops.push_back('{cmd: cmd, set_index: SET_IDX_W'(set_index),
                                way: WAY_W'(way), mask: mask});
        ops_queued++;
    endtask

    // Random transaction. Half the masks sit right around the limit so that
    // both trees see long walks; sets crowd into a few so trees build up history.
    task automatic queue_random_op();
        int               r;
        int               k;
        logic [CMD_W-1:0] cmd;
        logic [MASK_W-1:0] m;
        r = $urandom_range(0, 99);
        cmd = (r < 40) ? CMD_TOUCH : (r < 55) ? CMD_INVAL : (r < 96) ? CMD_VICTIM : CMD_UNUSED;
        r = $urandom_range(0, 9);
        m = '0;
        if (r < 5) begin
            k = $urandom_range(0, 3);
            k = k + int'(limit_model) - 1;
            if (k < 0)
                k = 0;
            if (k > WAYS)
                k = WAYS;
            while ($countones(m) < k)
                m[$urandom_range(0, WAYS - 1)] = 1'b1;
        end else if (r < 8) begin
            m = MASK_W'($urandom);
        end else if (r < 9) begin
            m = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            m[$urandom_range(0, WAYS - 1)] = 1'b1;
            if ($urandom_range(0, 1))
                m = ~m;
        end
        queue_op(cmd, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, SETS - 1),
                 $urandom_range(0, WAYS - 1), m);
    endtask

    // Hold until every queued transaction is taken and every victim has come back,
    // then let the longest search run out
    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((ops_accepted != ops_queued || victim_due.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic load_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limit_model = value;
    endtask

    initial begin : stimulus
        logic [LIMIT_W-1:0] limits [7];
        logic [MASK_W-1:0]  leftover;
        for (int s = 0; s < SETS; s++) begin
            lru_model[s]  = '0;
            keep_model[s] = '0;
        end
        limits = '{4'd0, 4'd15, 4'd3, LIMIT_W'($urandom_range(0, 15)), 4'd8, 4'd12, 4'd1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset limit of eight: extreme ways and sets,
        // every command, the spare command, counts on both sides of the limit,
        // and masks that force repeated walks
        queue_op(CMD_TOUCH,  0,  0,  16'h0000);
        queue_op(CMD_TOUCH,  0,  15, 16'hFFFF);
        queue_op(CMD_VICTIM, 0,  0,  16'h0000);
        queue_op(CMD_VICTIM, 0,  0,  16'hFFFF);
        queue_op(CMD_VICTIM, 0,  3,  16'h00FF);
        queue_op(CMD_VICTIM, 0,  3,  16'h01FF);
        queue_op(CMD_INVAL,  63, 0,  16'h0000);
        queue_op(CMD_INVAL,  63, 15, 16'h0000);
        queue_op(CMD_VICTIM, 63, 0,  16'h0000);
        queue_op(CMD_UNUSED, 0,  5,  16'hAAAA);
        queue_op(CMD_VICTIM, 0,  0,  16'h5555);
        queue_op(CMD_TOUCH,  63, 7,  16'h0000);
        queue_op(CMD_VICTIM, 63, 0,  16'h7FFF);
        queue_op(CMD_VICTIM, 63, 15, 16'h8000);
        queue_op(CMD_TOUCH,  42, 9,  16'h5A5A);
        queue_op(CMD_VICTIM, 42, 0,  16'hFFFE);
        queue_op(CMD_INVAL,  42, 9,  16'h0000);
        queue_op(CMD_VICTIM, 42, 0,  16'h0200);
        queue_op(CMD_VICTIM, 0,  0,  16'h0001);
        queue_op(CMD_VICTIM, 0,  0,  16'hFFFF);
        wait_idle();

        // Random phases, each under its own limit; every other phase runs back to back.
        // The sender stops at each boundary until all victims are in.
        foreach (limits[p]) begin
            load_limit(limits[p]);
            no_idle = (p % 2) == 1;
            repeat (PHASE_OPS) queue_random_op();
            wait_idle();
        end

        // Drop anything still outstanding as a failure
        while (victim_due.size() > 0) begin
            leftover = MASK_W'(victim_due.pop_front());
            flag_mismatch("victim never delivered", -1, int'(leftover));
        end
        if (ops_accepted != ops_queued)
            flag_mismatch("transactions never accepted", int'(ops_accepted), int'(ops_queued));

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
